// ===== sv/fhd_pkg.sv =====
// Shared types, codes and arithmetic helpers for the fingerprint distance table.
package fhd_pkg;

   // Command codes carried by an input beat.
   localparam logic CMD_DESC  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Status codes carried by a result beat.
   localparam logic [1:0] STATUS_ADDED    = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_FRICTION = 2'd2;

   // FNV-1a 64-bit offset basis.
   localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

   // Friction returned for unknown nodes and for a node paired with itself.
   localparam logic [15:0] FRICTION_UNKNOWN = 16'hFFFF;
   localparam logic [15:0] FRICTION_SAME    = 16'h0000;

   // Rounding offset of the Q16 scaling, which divides by 64.
   localparam logic [22:0] Q16_ROUND = 23'd32;

   typedef struct packed {
      logic       cmd;
      logic [7:0] desc_byte;
      logic       desc_last;
      logic [3:0] node_a;
      logic [3:0] node_b;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  new_index;
      logic [63:0] fingerprint;
      logic [15:0] friction;
   } rsp_type;

   // Start command handed to the distance walk.
   typedef struct packed {
      logic        start;
      logic [63:0] hash;
   } walk_cmd_type;

   // Multiply by the FNV prime 2^40 + 0x1B3 as a sum of shifted copies.
   function automatic logic [63:0] fnv_mul(input logic [63:0] x);
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   // Population count of a 64-bit word: eight byte counts, then their sum.
   function automatic logic [6:0] pop64(input logic [63:0] v);
      logic [3:0] part [8];
      logic [6:0] sum;
      for (int i = 0; i < 8; i++) begin
         part[i] = 4'd0;
         for (int j = 0; j < 8; j++) begin
            part[i] = part[i] + 4'(v[8*i+j]);
         end
      end
      sum = 7'd0;
      for (int i = 0; i < 8; i++) begin
         sum = sum + 7'(part[i]);
      end
      return sum;
   endfunction

   // Scale a distance of 0..64 bits to Q16 with rounding: (hd * 0xFFFF + 32) / 64.
   function automatic logic [15:0] to_q16(input logic [6:0] hd);
      logic [22:0] q;
      q = {hd, 16'h0000} - 23'(hd) + Q16_ROUND;
      return (q[22] == 1'b1) ? FRICTION_UNKNOWN : q[21:6];
   endfunction

endpackage

// ===== sv/fhd_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
module fhd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fhd_walk.sv =====
// Distance walk: reads each earlier fingerprint and writes its Q16 friction cell.
module fhd_walk #(
   parameter int MAX_NODES = 16,
   parameter int IDX_W = 4,
   parameter int CELL_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fhd_pkg::walk_cmd_type cmd,
   input  logic [IDX_W-1:0]      start_idx,
   output logic                  busy,
   output logic                  fp_rd_en,
   output logic [IDX_W-1:0]      fp_rd_addr,
   input  logic [63:0]           fp_rd_data,
   output logic                  fr_wr_en,
   output logic [CELL_W-1:0]     fr_wr_addr,
   output logic [15:0]           fr_wr_data
);

   typedef enum logic [1:0] {
      WALK_IDLE = 2'b01,
      WALK_READ = 2'b10
   } walk_state_type;

   // Distance from cell (e, idx) to cell (e+1, idx) is MAX_NODES - 2 - e.
   localparam logic [CELL_W:0] STEP_BASE = (CELL_W+1)'(MAX_NODES - 2);

   walk_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  e_ff, e_in;
   logic [IDX_W-1:0]  limit_ff, limit_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [63:0]       hash_ff, hash_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [CELL_W-1:0] s1_cell_ff;
   logic              s2_valid_ff, s2_valid_in;
   logic [CELL_W-1:0] s2_cell_ff;
   logic [6:0]        hd_ff;
   logic              last_read;
   logic [CELL_W:0]   cell_step;

   assign last_read = ({1'b0, e_ff} + (IDX_W+1)'(1)) == {1'b0, limit_ff};
   assign cell_step = {1'b0, cell_ff} + STEP_BASE - (CELL_W+1)'(e_ff);

   // Read sequencer over the earlier nodes.
   always_comb begin
      state_in = state_ff;
      e_in     = e_ff;
      limit_in = limit_ff;
      cell_in  = cell_ff;
      hash_in  = hash_ff;
      case (state_ff)
         WALK_IDLE: begin
            if (cmd.start && (start_idx != '0)) begin
               state_in = WALK_READ;
               e_in     = '0;
               limit_in = start_idx;
               cell_in  = CELL_W'(start_idx - IDX_W'(1));
               hash_in  = cmd.hash;
            end
         end
         WALK_READ: begin
            e_in    = e_ff + IDX_W'(1);
            cell_in = cell_step[CELL_W-1:0];
            if (last_read) begin
               state_in = WALK_IDLE;
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase
   end

   assign s1_valid_in = (state_ff == WALK_READ);
   assign s2_valid_in = s1_valid_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= WALK_IDLE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Datapath registers: counters, then distance pipeline.
   always_ff @(posedge clock) begin
      e_ff       <= e_in;
      limit_ff   <= limit_in;
      cell_ff    <= cell_in;
      hash_ff    <= hash_in;
      s1_cell_ff <= cell_ff;
      s2_cell_ff <= s1_cell_ff;
      hd_ff      <= fhd_pkg::pop64(fp_rd_data ^ hash_ff);
   end

   assign fp_rd_en   = (state_ff == WALK_READ);
   assign fp_rd_addr = e_ff;
   assign fr_wr_en   = s2_valid_ff;
   assign fr_wr_addr = s2_cell_ff;
   assign fr_wr_data = fhd_pkg::to_q16(hd_ff);
   assign busy       = (state_ff != WALK_IDLE) || s1_valid_ff || s2_valid_ff;

endmodule

// ===== sv/fingerprint_hamming_distance_table.sv =====
// Top level of the fingerprint distance table: hashing, node store, queries, result beat.
// Descriptor bytes are folded into an FNV-1a 64-bit hash at one beat per cycle while
// req_stall is low. A final byte gives the hash to the next free node slot and returns
// the node-added beat at once (or a table-full beat), then walks the earlier nodes
// through the fingerprint memory's read port, one node per cycle: adding node n, for n
// above zero, keeps req_stall high until its last friction cell is written, and adding
// node 0 starts no walk. A friction query reads the friction memory into its registered
// read port, then loads the result register. A result beat waits in its own register;
// while it is stalled, no new beat is accepted. There is no clearing pass after reset;
// a memory entry's value is only used once written.
module fingerprint_hamming_distance_table #(
   parameter int MAX_NODES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fhd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fhd_pkg::rsp_type rsp_data
);

   localparam int CNT_W      = $clog2(MAX_NODES + 1);
   localparam int IDX_W      = $clog2(MAX_NODES);
   localparam int CELL_COUNT = MAX_NODES * (MAX_NODES - 1) / 2;
   localparam int CELL_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int PROD_W     = CELL_W + 4;

   logic [63:0]      hash_ff, hash_in;
   logic [CNT_W-1:0] node_count_ff, node_count_in;
   logic             q_pending_ff;
   logic             q_unknown_ff;
   logic             q_same_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   fhd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        is_query;
   logic        desc_done;
   logic        table_full;
   logic        add_node;
   logic        query_accept;
   logic [63:0] hash_next;
   logic        walk_busy;

   logic        a_known;
   logic        b_known;
   logic [3:0]  lo_node;
   logic [3:0]  hi_node;
   logic [PROD_W-1:0] cell_prod;
   logic [PROD_W-1:0] cell_sum;

   fhd_pkg::walk_cmd_type walk_cmd;
   logic              fp_rd_en;
   logic [IDX_W-1:0]  fp_rd_addr;
   logic [63:0]       fp_rd_data;
   logic              fr_wr_en;
   logic [CELL_W-1:0] fr_wr_addr;
   logic [15:0]       fr_wr_data;
   logic [15:0]       fr_rd_data;

   // Input handshake: hold off during a walk, a pending query or a stalled result.
   assign req_stall    = walk_busy || q_pending_ff || (rsp_valid_ff && rsp_stall);
   assign accept       = req_valid && !req_stall;
   assign is_query     = (req_data.cmd == fhd_pkg::CMD_QUERY);
   assign query_accept = accept && is_query;
   assign desc_done    = accept && !is_query && req_data.desc_last;
   assign table_full   = (node_count_ff >= CNT_W'(MAX_NODES));
   assign add_node     = desc_done && !table_full;
   assign hash_next    = fhd_pkg::fnv_mul(hash_ff ^ {56'h0, req_data.desc_byte});

   // Hash accumulator and node count.
   always_comb begin
      hash_in       = hash_ff;
      node_count_in = node_count_ff;
      if (accept && !is_query) begin
         hash_in = req_data.desc_last ? fhd_pkg::FNV_BASIS : hash_next;
      end
      if (add_node) begin
         node_count_in = node_count_ff + CNT_W'(1);
      end
   end

   // Query decode: known nodes, same node, packed upper-triangular cell address.
   assign a_known   = {CNT_W'(0), req_data.node_a} < {4'h0, node_count_ff};
   assign b_known   = {CNT_W'(0), req_data.node_b} < {4'h0, node_count_ff};
   assign lo_node   = (req_data.node_a < req_data.node_b) ? req_data.node_a : req_data.node_b;
   assign hi_node   = (req_data.node_a < req_data.node_b) ? req_data.node_b : req_data.node_a;
   assign cell_prod = PROD_W'(lo_node) * (PROD_W'(2 * MAX_NODES - 1) - PROD_W'(lo_node));
   assign cell_sum  = (cell_prod >> 1) + PROD_W'(hi_node) - PROD_W'(lo_node) - PROD_W'(1);

   // Result register: loaded by a finished descriptor or a completed query read.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (desc_done) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = table_full ? fhd_pkg::STATUS_FULL : fhd_pkg::STATUS_ADDED;
         rsp_data_in.new_index   = table_full ? 4'h0 : 4'(node_count_ff);
         rsp_data_in.fingerprint = hash_next;
         rsp_data_in.friction    = 16'h0000;
      end else if (q_pending_ff) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = fhd_pkg::STATUS_FRICTION;
         rsp_data_in.new_index   = 4'h0;
         rsp_data_in.fingerprint = 64'h0;
         if (q_unknown_ff) begin
            rsp_data_in.friction = fhd_pkg::FRICTION_UNKNOWN;
         end else if (q_same_ff) begin
            rsp_data_in.friction = fhd_pkg::FRICTION_SAME;
         end else begin
            rsp_data_in.friction = fr_rd_data;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff       <= fhd_pkg::FNV_BASIS;
         node_count_ff <= '0;
         q_pending_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hash_ff       <= hash_in;
         node_count_ff <= node_count_in;
         q_pending_ff  <= query_accept;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      q_unknown_ff <= !(a_known && b_known);
      q_same_ff    <= (req_data.node_a == req_data.node_b);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Fingerprint store: written by a new node, read by the walk.
   fhd_ram #(
      .WIDTH (64),
      .DEPTH (MAX_NODES),
      .ADDR_W(IDX_W)
   ) u_fp_ram (
      .clock  (clock),
      .wr_en  (add_node),
      .wr_addr(node_count_ff[IDX_W-1:0]),
      .wr_data(hash_next),
      .rd_en  (fp_rd_en),
      .rd_addr(fp_rd_addr),
      .rd_data(fp_rd_data)
   );

   // Friction store: written by the walk, read by queries.
   fhd_ram #(
      .WIDTH (16),
      .DEPTH (CELL_COUNT),
      .ADDR_W(CELL_W)
   ) u_fr_ram (
      .clock  (clock),
      .wr_en  (fr_wr_en),
      .wr_addr(fr_wr_addr),
      .wr_data(fr_wr_data),
      .rd_en  (query_accept),
      .rd_addr(cell_sum[CELL_W-1:0]),
      .rd_data(fr_rd_data)
   );

   assign walk_cmd.start = add_node;
   assign walk_cmd.hash  = hash_next;

   // Distance walk over the earlier nodes.
   fhd_walk #(
      .MAX_NODES(MAX_NODES),
      .IDX_W    (IDX_W),
      .CELL_W   (CELL_W)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .cmd       (walk_cmd),
      .start_idx (node_count_ff[IDX_W-1:0]),
      .busy      (walk_busy),
      .fp_rd_en  (fp_rd_en),
      .fp_rd_addr(fp_rd_addr),
      .fp_rd_data(fp_rd_data),
      .fr_wr_en  (fr_wr_en),
      .fr_wr_addr(fr_wr_addr),
      .fr_wr_data(fr_wr_data)
   );

endmodule

// ===== sv/fhd_checker.sv =====
// Port-level checker for the fingerprint distance table, bound to the top level.
module fhd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input fhd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fhd_pkg::rsp_type rsp_data
);

   logic req_beat;
   logic query_beat;
   logic byte_beat;

   assign req_beat   = req_valid && !req_stall;
   assign query_beat = req_beat && (req_data.cmd == fhd_pkg::CMD_QUERY);
   assign byte_beat  = req_beat && (req_data.cmd == fhd_pkg::CMD_DESC) && !req_data.desc_last;

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   // A query beat is answered with a friction result, through the friction read and the result register.
   assert property (@(posedge clock) disable iff (reset)
      query_beat |-> ##2 (rsp_valid && rsp_data.status == fhd_pkg::STATUS_FRICTION))
      else $error("query not answered in two cycles");

   // A node paired with itself reads either as unknown or as zero friction.
   assert property (@(posedge clock) disable iff (reset)
      query_beat && (req_data.node_a == req_data.node_b) |-> ##2
         (rsp_data.friction == fhd_pkg::FRICTION_SAME ||
          rsp_data.friction == fhd_pkg::FRICTION_UNKNOWN))
      else $error("self pair friction is neither zero nor unknown");

   // A non-final descriptor byte produces no result beat.
   assert property (@(posedge clock) disable iff (reset)
      byte_beat && !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("result beat after a non-final descriptor byte");

endmodule

bind fingerprint_hamming_distance_table fhd_checker u_fhd_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

// ===== test/tb_fingerprint_hamming_distance_table.sv =====
// Testbench for the fingerprint distance table: directed and random beats checked by a predictor.
`timescale 1ns / 1ps

module tb_fingerprint_hamming_distance_table;

   localparam int MAX_NODES = 16;
   localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1030;
   localparam int REQ_W = $bits(fhd_pkg::req_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   fhd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   fhd_pkg::rsp_type rsp_data;

   // Predictor state: running hash, stored fingerprints and pair scores.
   logic [63:0] running_hash = fhd_pkg::FNV_BASIS;
   int unsigned stored_nodes = 0;
   logic [63:0] node_prints [MAX_NODES];
   logic [15:0] pair_score [MAX_NODES][MAX_NODES];

   fhd_pkg::rsp_type expected_results [$];
   int failures = 0;
   int cycle_count = 0;
   bit steady = 1'b0;

   fingerprint_hamming_distance_table #(
      .MAX_NODES(MAX_NODES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_fingerprint_hamming_distance_table: FAIL");
         $finish;
      end
   end

   // The receiver stalls at random, except during the steady stretch.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 36);
   end

   // Distance between two fingerprints scaled to Q16 with rounding.
   function automatic logic [15:0] scaled_distance(input logic [63:0] x, input logic [63:0] y);
      int unsigned hd;
      int unsigned q;
      hd = $countones(x ^ y);
      q = (hd * 32'hFFFF + 32) / 64;
      return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
   endfunction

   // Works out the result of one accepted beat and queues it, if the beat causes one.
   function automatic void predict_table(input fhd_pkg::req_type beat);
      fhd_pkg::rsp_type res;
      logic [63:0] folded;
      res = '0;
      if (beat.cmd == fhd_pkg::CMD_DESC) begin
         folded = (running_hash ^ {56'd0, beat.desc_byte}) * FNV_PRIME;
         if (!beat.desc_last) begin
            running_hash = folded;
            return;
         end
         running_hash = fhd_pkg::FNV_BASIS;
         res.fingerprint = folded;
         if (stored_nodes >= MAX_NODES) begin
            res.status = fhd_pkg::STATUS_FULL;
         end else begin
            node_prints[stored_nodes] = folded;
            for (int e = 0; e < stored_nodes; e++) begin
               pair_score[e][stored_nodes] = scaled_distance(node_prints[e], folded);
               pair_score[stored_nodes][e] = pair_score[e][stored_nodes];
            end
            res.status = fhd_pkg::STATUS_ADDED;
            res.new_index = stored_nodes[3:0];
            stored_nodes++;
         end
      end else begin
         res.status = fhd_pkg::STATUS_FRICTION;
         if (beat.node_a >= stored_nodes || beat.node_b >= stored_nodes) begin
            res.friction = fhd_pkg::FRICTION_UNKNOWN;
         end else if (beat.node_a == beat.node_b) begin
            res.friction = fhd_pkg::FRICTION_SAME;
         end else begin
            res.friction = pair_score[beat.node_a][beat.node_b];
         end
      end
      expected_results.push_back(res);
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   // Each accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      fhd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result beat with status %0d", rsp_data.status);
            failures++;
         end else begin
            want = expected_results.pop_front();
            compare_field("status", want.status, rsp_data.status);
            compare_field("new_index", want.new_index, rsp_data.new_index);
            compare_field("fingerprint", want.fingerprint, rsp_data.fingerprint);
            compare_field("friction", want.friction, rsp_data.friction);
         end
      end
   end

   // Sends one beat after an optional random gap and waits for it to be taken.
   task automatic send_beat(input fhd_pkg::req_type beat);
      while (!steady && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_table(beat);
   endtask

   // Descriptor beat; the unused node fields carry random noise.
   function automatic fhd_pkg::req_type desc_beat(input logic [7:0] value, input logic last);
      fhd_pkg::req_type beat;
      beat = fhd_pkg::req_type'(REQ_W'($urandom));
      beat.cmd = fhd_pkg::CMD_DESC;
      beat.desc_byte = value;
      beat.desc_last = last;
      return beat;
   endfunction

   // Query beat; the unused descriptor fields carry random noise.
   function automatic fhd_pkg::req_type query_beat(input logic [3:0] a, input logic [3:0] b);
      fhd_pkg::req_type beat;
      beat = fhd_pkg::req_type'(REQ_W'($urandom));
      beat.cmd = fhd_pkg::CMD_QUERY;
      beat.node_a = a;
      beat.node_b = b;
      return beat;
   endfunction

   // Holds the sender off until every expected result has arrived and the walk is over.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (MAX_NODES + 8) @(posedge clock);
   endtask

   // Queries on an empty table report unknown nodes.
   task automatic test_empty_table();
      send_beat(query_beat(4'd0, 4'd0));
      send_beat(query_beat(4'd15, 4'd15));
      send_beat(query_beat(4'd3, 4'd9));
   endtask

   // First nodes: single-byte extremes, a query inside a descriptor, same and unknown pairs.
   task automatic test_first_nodes();
      send_beat(desc_beat(8'h00, 1'b1));
      send_beat(query_beat(4'd0, 4'd0));
      send_beat(query_beat(4'd0, 4'd1));
      send_beat(desc_beat(8'hFF, 1'b1));
      send_beat(query_beat(4'd0, 4'd1));
      send_beat(query_beat(4'd1, 4'd0));
      send_beat(desc_beat(8'h5A, 1'b0));
      send_beat(desc_beat(8'hA5, 1'b0));
      send_beat(query_beat(4'd1, 4'd0));
      send_beat(desc_beat(8'h80, 1'b1));
      send_beat(query_beat(4'd2, 4'd0));
      send_beat(query_beat(4'd1, 4'd2));
      send_beat(query_beat(4'd2, 4'd2));
      send_beat(query_beat(4'd2, 4'd3));
      send_beat(query_beat(4'd15, 4'd2));
   endtask

   // Picks a node index, mostly among the stored nodes.
   function automatic logic [3:0] pick_node();
      if (stored_nodes > 0 && $urandom_range(99) < 75) begin
         return 4'($urandom_range(stored_nodes - 1));
      end
      return 4'($urandom_range(15));
   endfunction

   // Random traffic: whole descriptors, queries, and fully random beats.
   task automatic test_random_traffic(input int unsigned item_goal);
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      sent = 0;
      while (sent < item_goal) begin
         steady = (sent >= item_goal / 3) && (sent < item_goal / 3 + 200);
         pick = $urandom_range(99);
         if (pick < 30) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               // Now and then a query lands in the middle of a descriptor.
               if (i > 0 && $urandom_range(99) < 25) begin
                  send_beat(query_beat(pick_node(), pick_node()));
                  sent++;
               end
               send_beat(desc_beat(8'($urandom_range(255)), i == len - 1));
               sent++;
            end
         end else if (pick < 90) begin
            send_beat(query_beat(pick_node(), pick_node()));
            sent++;
         end else begin
            send_beat(fhd_pkg::req_type'(REQ_W'($urandom)));
            sent++;
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_first_nodes();
      wait_results_drained();
      test_random_traffic(RANDOM_ITEMS);
      wait_results_drained();
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("tb_fingerprint_hamming_distance_table: PASS");
      end else begin
         $display("tb_fingerprint_hamming_distance_table: FAIL");
      end
      $finish;
   end

endmodule
